// ===== design/bbc_pkg.sv =====
// Shared constants, codes and types for the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH   = 64;
    localparam int POSITION_BITS = 32;
    localparam int COUNT_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int KIND_BITS     = 3;
    localparam int STATUS_BITS   = 3;
    localparam int DEPTH_BITS    = 7;
    localparam int IN_USER_BITS  = KIND_BITS + 1;
    localparam int OUT_DATA_RAW  = POSITION_BITS + DEPTH_BITS;
    localparam int OUT_DATA_BITS = ((OUT_DATA_RAW + 7) / 8) * 8;

    localparam logic [KIND_BITS-1:0] KIND_OPEN_ROUND   = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_OPEN_SQUARE  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_CLOSE_ROUND  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_CLOSE_SQUARE = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_PENDING  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BALANCED = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNCLOSED = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EXCESS   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_MISMATCH = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_IGNORED  = 3'd6;

    typedef struct packed {
        logic                     square;
        logic [POSITION_BITS-1:0] position;
    } stack_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== design/bracket_balance_checker_unit.sv =====
// Top level of the bracket balance checker: query control and the row of stack cells.
// A result is registered and appears on the master side in the cycle after its token is accepted.
// Throughput: one token per cycle unless m_tready stalls; on a push or a pop every cell
// shifts one place at once, and only the top two cells are read, so the output keeps pace.
// Reset: aresetn clears the depth count, session mark, error flag and output valid.
// The stack cells need no clearing, since the depth count alone marks live entries.
module bracket_balance_checker_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bbc_pkg::POSITION_BITS-1:0]     s_tdata,  // position
    input  logic [bbc_pkg::IN_USER_BITS-1:0]      s_tuser,  // kind, after_session
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bbc_pkg::OUT_DATA_BITS-1:0]     m_tdata,  // error_position, open_depth
    output logic [bbc_pkg::STATUS_BITS-1:0]       m_tuser,  // status
    output logic                                  m_tlast
);
    import bbc_pkg::*;

    logic                     accept;
    logic [KIND_BITS-1:0]     kind;
    logic                     after_session;
    logic                     is_open;
    logic                     is_close;
    logic                     want_square;
    stack_entry_t             new_entry;
    cell_ctrl_t               ctrl;
    stack_entry_t             cells [STACK_DEPTH];

    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;
    logic [COUNT_BITS-1:0]    depth_out;
    logic                     session_valid_reg;
    logic                     session_valid_next;
    logic [POSITION_BITS-1:0] session_pos_reg;
    logic [POSITION_BITS-1:0] session_pos_next;
    logic                     error_seen_reg;
    logic                     error_seen_next;
    logic [STATUS_BITS-1:0]   status;
    logic [POSITION_BITS-1:0] err_pos;
    logic [POSITION_BITS-1:0] top_after;

    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [STATUS_BITS-1:0]   m_status_reg;
    logic [POSITION_BITS-1:0] m_err_pos_reg;
    logic [DEPTH_BITS-1:0]    m_depth_reg;
    logic                     m_last_reg;

    assign s_tready      = !m_valid_reg || m_tready;
    assign accept        = s_tvalid && s_tready;
    assign kind          = s_tuser[KIND_BITS-1:0];
    assign after_session = s_tuser[KIND_BITS];
    assign is_open       = (kind == KIND_OPEN_ROUND) || (kind == KIND_OPEN_SQUARE);
    assign is_close      = (kind == KIND_CLOSE_ROUND) || (kind == KIND_CLOSE_SQUARE);
    assign want_square   = (kind == KIND_CLOSE_SQUARE);
    assign new_entry.square   = (kind == KIND_OPEN_SQUARE);
    assign new_entry.position = s_tdata;

    always_comb begin
        ctrl               = '0;
        status             = ST_PENDING;
        err_pos            = '0;
        count_next         = count_reg;
        session_valid_next = session_valid_reg;
        session_pos_next   = session_pos_reg;
        error_seen_next    = error_seen_reg;
        top_after          = cells[0].position;
        depth_out          = count_reg;
        if (accept) begin
            if (error_seen_reg) begin
                status = ST_IGNORED;
            end else begin
                if (is_open) begin
                    if (count_reg == COUNT_BITS'(STACK_DEPTH)) begin
                        status = ST_OVERFLOW;
                    end else begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + COUNT_BITS'(1);
                        top_after  = s_tdata;
                        if ((kind == KIND_OPEN_ROUND) && after_session) begin
                            session_valid_next = 1'b1;
                            session_pos_next   = s_tdata;
                        end
                    end
                end else if (is_close) begin
                    if (count_reg == '0) begin
                        status = ST_EXCESS;
                    end else if ((cells[0].square == want_square) ||
                                 (session_valid_reg && (count_reg >= COUNT_BITS'(2)) &&
                                  (cells[1].position == session_pos_reg))) begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - COUNT_BITS'(1);
                        top_after  = cells[1].position;
                    end else begin
                        status = ST_MISMATCH;
                    end
                end
                if (status != ST_PENDING) begin
                    error_seen_next = 1'b1;
                    err_pos         = s_tdata;
                end else if (s_tlast) begin
                    if (count_next == '0) begin
                        status = ST_BALANCED;
                    end else begin
                        status  = ST_UNCLOSED;
                        err_pos = top_after;
                    end
                end
            end
            depth_out = count_next;
            if (s_tlast) begin
                count_next         = '0;
                session_valid_next = 1'b0;
                session_pos_next   = '0;
                error_seen_next    = 1'b0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
            stack_entry_t above;
            stack_entry_t below;
            if (i == 0) begin : g_top
                assign above = new_entry;
            end else begin : g_mid
                assign above = cells[i-1];
            end
            if (i == STACK_DEPTH - 1) begin : g_bottom
                assign below = cells[i];
            end else begin : g_rest
                assign below = cells[i+1];
            end
            bbc_cell u_cell (
                .aclk  (aclk),
                .ctrl  (ctrl),
                .above (above),
                .below (below),
                .entry (cells[i])
            );
        end
    endgenerate

    assign m_valid_next = accept || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg         <= '0;
            session_valid_reg <= 1'b0;
            session_pos_reg   <= '0;
            error_seen_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            count_reg         <= count_next;
            session_valid_reg <= session_valid_next;
            session_pos_reg   <= session_pos_next;
            error_seen_reg    <= error_seen_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg  <= status;
            m_err_pos_reg <= err_pos;
            m_depth_reg   <= DEPTH_BITS'(depth_out);
            m_last_reg    <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_DATA_BITS'({m_depth_reg, m_err_pos_reg});

endmodule

// ===== design/bbc_cell.sv =====
// One stack cell: takes the entry above on a push and the entry below on a pop.
module bbc_cell (
    input  logic                  aclk,
    input  bbc_pkg::cell_ctrl_t   ctrl,
    input  bbc_pkg::stack_entry_t above,
    input  bbc_pkg::stack_entry_t below,
    output bbc_pkg::stack_entry_t entry
);
    import bbc_pkg::*;

    stack_entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            entry_reg <= above;
        end else if (ctrl.pop) begin
            entry_reg <= below;
        end
    end

    assign entry = entry_reg;

endmodule
